/* hw/rtl/fra_pkg.sv */
// Package for the frame range allocator: operation and status codes, field widths.
// No dependencies.
package fra_pkg;
    localparam int FW = 52;
    localparam int LW = 53;
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE = 2'd1;
    localparam logic [1:0] OP_RSV = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;
endpackage

/* hw/rtl/fra_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/frame_range_allocator_core.sv */
// Top level of the frame range allocator: sequencer over a region table in RAM.
// Depends on fra_pkg and fra_ram.
//
// channel | dir | fields (tdata low to high)
// s_axis  | in  | operation[1:0], first_frame[53:2], frame_count[106:54], end_frame[159:107]
// m_axis  | out | status[1:0], frame[53:2]
//
// Allocate and reserve read, check and step past each table slot scanned; a free scan
// reads and checks each slot, up to MAX_REGIONS slots for each scan; a reserve walks all
// used slots and may run two free scans per slot. The single table read port sets the
// pace. After reset a clearing pass writes every table slot before the first request is
// taken. A result waits in the output register; no new request is taken until it leaves.
module frame_range_allocator_core #(
    parameter int MAX_REGIONS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,  // operation, first_frame, frame_count, end_frame
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata   // status, frame
);
    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [fra_pkg::LW-1:0] LMAX = '1;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_RD     = 12'b000000000100,
        S_CHK    = 12'b000000001000,
        S_FRD    = 12'b000000010000,
        S_FCHK   = 12'b000000100000,
        S_ERD    = 12'b000001000000,
        S_ECHK   = 12'b000010000000,
        S_FPUT   = 12'b000100000000,
        S_RNEXT  = 12'b001000000000,
        S_OUT    = 12'b010000000000,
        S_REM2   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]  r_op;
    logic [fra_pkg::FW-1:0] r_first;
    logic [fra_pkg::LW-1:0] r_count, r_end;
    logic [CW-1:0] r_used, r_i, r_j;
    logic [1:0]  r_st;
    logic [fra_pkg::FW-1:0] r_frame;
    logic        r_ovalid;
    // remnant free parameters and context
    logic [fra_pkg::LW-1:0] r_ffirst;
    logic [fra_pkg::LW-1:0] r_fcount;
    logic        r_inrsv;
    logic [fra_pkg::LW:0]   r_rbe;
    logic [fra_pkg::LW-1:0] r_rend;
    logic        r_rem2;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [fra_pkg::FW-1:0] wbase, rbase;
    logic [fra_pkg::LW-1:0] wlen, rlen;

    fra_ram #(.WIDTH(fra_pkg::FW), .DEPTH(MAX_REGIONS)) u_base (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wbase),
        .i_raddr(raddr), .o_rdata(rbase));
    fra_ram #(.WIDTH(fra_pkg::LW), .DEPTH(MAX_REGIONS)) u_len (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wlen),
        .i_raddr(raddr), .o_rdata(rlen));

    logic [fra_pkg::LW:0] fend, bend, sum;
    logic [fra_pkg::LW-1:0] satlen;
    logic [fra_pkg::LW:0] rs, re;
    assign fend = {1'b0, r_fcount} + {1'b0, r_ffirst};
    assign bend = {2'b0, rbase} + {1'b0, rlen};
    assign sum = {1'b0, rlen} + {1'b0, r_fcount};
    assign satlen = sum[fra_pkg::LW] ? LMAX : sum[fra_pkg::LW-1:0];
    assign rs = {2'b0, r_first};
    assign re = {1'b0, r_end};

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {2'b0, r_frame, r_st};

    logic [CW-1:0] scan;
    always_comb begin
        scan = r_j;
        case (r_state)
            S_RD, S_CHK: scan = r_i;
            default: scan = r_j;
        endcase
        raddr = scan[AW-1:0];
    end

    logic [fra_pkg::LW-1:0] n_ffirst;
    logic [fra_pkg::LW-1:0] n_fcount;
    logic [CW-1:0] n_used, n_i, n_j;
    logic [1:0] n_st;
    logic [fra_pkg::FW-1:0] n_frame;
    logic n_ovalid, n_inrsv, n_rem2;

    always_comb begin
        n_state = r_state;
        n_ffirst = r_ffirst; n_fcount = r_fcount;
        n_used = r_used; n_i = r_i; n_j = r_j;
        n_st = r_st; n_frame = r_frame; n_ovalid = r_ovalid;
        n_inrsv = r_inrsv; n_rem2 = r_rem2;
        we = 1'b0; waddr = r_j[AW-1:0]; wbase = '0; wlen = '0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                n_j = r_j + 1'b1;
                if (r_j == CW'(MAX_REGIONS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_st = fra_pkg::ST_OK; n_frame = '0; n_i = '0; n_j = '0;
                    n_inrsv = 1'b0;
                    n_ffirst = {1'b0, s_axis_tdata[53:2]};
                    n_fcount = s_axis_tdata[106:54];
                    case (s_axis_tdata[1:0])
                        fra_pkg::OP_ALLOC: n_state = S_RD;
                        fra_pkg::OP_FREE: n_state = S_FRD;
                        fra_pkg::OP_RSV: begin
                            if (s_axis_tdata[53:2] > s_axis_tdata[159:107]) begin
                                n_st = fra_pkg::ST_ORDER; n_state = S_OUT;
                            end else begin
                                n_inrsv = 1'b1; n_state = S_RD;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_RD: begin
                if (r_i >= r_used) begin
                    if (r_op == fra_pkg::OP_ALLOC) n_st = fra_pkg::ST_NOFIT;
                    n_state = S_OUT;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_RNEXT;
                waddr = r_i[AW-1:0];
                if (r_op == fra_pkg::OP_ALLOC) begin
                    if (rlen >= r_count) begin
                        we = 1'b1; wbase = rbase + r_count[fra_pkg::FW-1:0];
                        wlen = rlen - r_count; n_frame = rbase; n_state = S_OUT;
                    end
                end else if ({2'b0, rbase} >= rs && bend <= re) begin
                    we = 1'b1; wbase = rbase; wlen = '0;
                end else if (rs <= {2'b0, rbase} && re < bend && re >= {2'b0, rbase}) begin
                    we = 1'b1; wbase = r_end[fra_pkg::FW-1:0];
                    wlen = fra_pkg::LW'(bend - re);
                end else if (rs > {2'b0, rbase} && rs <= bend && re >= bend) begin
                    we = 1'b1; wbase = rbase; wlen = fra_pkg::LW'(rs - {2'b0, rbase});
                end else if (rs >= {2'b0, rbase} && re <= bend) begin
                    we = 1'b1; wbase = rbase; wlen = '0;
                    n_ffirst = {1'b0, rbase}; n_fcount = fra_pkg::LW'(rs - {2'b0, rbase});
                    n_rem2 = 1'b1; n_j = '0;
                    n_state = (n_fcount == '0) ? S_REM2 : S_FRD;
                end
            end
            S_RNEXT: begin
                n_i = r_i + 1'b1; n_state = S_RD;
            end
            S_REM2: begin
                n_ffirst = r_rend;
                n_fcount = fra_pkg::LW'(r_rbe - {1'b0, r_rend});
                n_rem2 = 1'b0; n_j = '0;
                n_state = (n_fcount == '0) ? S_RNEXT : S_FRD;
            end
            S_FRD: begin
                if (r_fcount == '0) begin
                    n_state = r_inrsv ? S_RNEXT : S_OUT;
                end else if (r_j >= r_used) begin
                    n_j = '0; n_state = S_ERD;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                n_state = S_FRD; n_j = r_j + 1'b1;
                if ({2'b0, rbase} == fend) begin
                    we = 1'b1; wbase = r_ffirst[fra_pkg::FW-1:0]; wlen = satlen;
                    n_state = S_FPUT;
                end else if (bend == {1'b0, r_ffirst}) begin
                    we = 1'b1; wbase = rbase; wlen = satlen; n_state = S_FPUT;
                end
            end
            S_ERD: begin
                if (r_j >= r_used) begin
                    if (r_j >= CW'(MAX_REGIONS)) begin
                        n_st = fra_pkg::ST_FULL; n_state = S_FPUT;
                    end else begin
                        we = 1'b1; wbase = r_ffirst[fra_pkg::FW-1:0]; wlen = r_fcount;
                        n_used = r_j + 1'b1; n_state = S_FPUT;
                    end
                end else begin
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                if (rlen == '0) begin
                    we = 1'b1; wbase = r_ffirst[fra_pkg::FW-1:0]; wlen = r_fcount;
                    n_state = S_FPUT;
                end else begin
                    n_j = r_j + 1'b1; n_state = S_ERD;
                end
            end
            S_FPUT: begin
                if (!r_inrsv) n_state = S_OUT;
                else n_state = r_rem2 ? S_REM2 : S_RNEXT;
            end
            S_OUT: begin
                n_ovalid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_used <= '0; r_i <= '0; r_j <= '0;
            r_ovalid <= 1'b0; r_inrsv <= 1'b0; r_rem2 <= 1'b0;
        end else begin
            r_state <= n_state; r_used <= n_used; r_i <= n_i; r_j <= n_j;
            r_ovalid <= n_ovalid; r_inrsv <= n_inrsv; r_rem2 <= n_rem2;
        end
        r_st <= n_st; r_frame <= n_frame;
        r_ffirst <= n_ffirst; r_fcount <= n_fcount;
        if (s_axis_tvalid && s_axis_tready) begin
            r_op <= s_axis_tdata[1:0];
            r_first <= s_axis_tdata[53:2];
            r_count <= s_axis_tdata[106:54];
            r_end <= s_axis_tdata[159:107];
        end
        if (r_state == S_CHK) begin
            r_rbe <= bend; r_rend <= r_end;
        end
    end

`ifndef SYNTHESIS
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_REGIONS)) else $error("table count past depth");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("ready while busy");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT)) else $error("stray result");
`endif
endmodule

/* test/frame_range_allocator_core_tb.sv */
// Testbench for frame_range_allocator_core: directed table then random requests,
// checked against a behavioral region table. Depends on fra_pkg and the core RTL.
`timescale 1ns / 100ps

module frame_range_allocator_core_tb;

    localparam int NREG = 64;
    localparam int NDIR = 20;
    localparam longint LIMIT = 3000000;
    localparam logic [52:0] MAX53 = {53{1'b1}};
    localparam logic [51:0] MAX52 = {52{1'b1}};

    typedef struct packed {
        logic [1:0]  op;
        logic [51:0] first;
        logic [52:0] count;
        logic [52:0] fend;
    } t_req;

    typedef struct packed {
        logic [1:0]  st;
        logic [51:0] frame;
    } t_res;

    typedef struct {
        t_req       rq;
        logic       fixed;
        logic [1:0] st;
        logic [51:0] frame;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;

    logic [51:0] tbl_base [NREG];
    logic [52:0] tbl_len [NREG];
    int          tbl_used;

    t_res   pending_results[$];
    t_res   fixed_results[$];
    logic   fixed_flags[$];
    int     fails;
    longint cycle;
    logic   quiet;
    logic   hold_rx;
    t_row   rows[NDIR];

    frame_range_allocator_core #(.MAX_REGIONS(NREG)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [52:0] sat_add(logic [52:0] a, logic [52:0] b);
        logic [53:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[53] ? MAX53 : s[52:0];
    endfunction

    function automatic logic [1:0] tbl_free(logic [52:0] first, logic [52:0] count);
        int i;
        logic [53:0] e;
        if (count == 0) return fra_pkg::ST_OK;
        for (i = 0; i < tbl_used; i++) begin
            if ({2'b0, tbl_base[i]} == {1'b0, first} + {1'b0, count}) begin
                tbl_base[i] = first[51:0];
                tbl_len[i] = sat_add(tbl_len[i], count);
                return fra_pkg::ST_OK;
            end
            e = {2'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
            if (e == {1'b0, first}) begin
                tbl_len[i] = sat_add(tbl_len[i], count);
                return fra_pkg::ST_OK;
            end
        end
        for (i = 0; i < tbl_used; i++)
            if (tbl_len[i] == 0) break;
        if (i >= NREG) return fra_pkg::ST_FULL;
        if (i >= tbl_used) tbl_used = i + 1;
        tbl_base[i] = first[51:0];
        tbl_len[i] = count;
        return fra_pkg::ST_OK;
    endfunction

    function automatic t_res predict_request(t_req rq);
        t_res r;
        int i;
        logic [53:0] bs, be, s, e;
        r = '0;
        case (rq.op)
            fra_pkg::OP_ALLOC: begin
                r.st = fra_pkg::ST_NOFIT;
                for (i = 0; i < tbl_used; i++) begin
                    if (tbl_len[i] >= rq.count) begin
                        r.st = fra_pkg::ST_OK;
                        r.frame = tbl_base[i];
                        tbl_base[i] = tbl_base[i] + rq.count[51:0];
                        tbl_len[i] = tbl_len[i] - rq.count;
                        break;
                    end
                end
            end
            fra_pkg::OP_FREE: r.st = tbl_free({1'b0, rq.first}, rq.count);
            fra_pkg::OP_RSV: begin
                s = {2'b0, rq.first};
                e = {1'b0, rq.fend};
                if (s > e) begin
                    r.st = fra_pkg::ST_ORDER;
                end else begin
                    for (i = 0; i < tbl_used; i++) begin
                        bs = {2'b0, tbl_base[i]};
                        be = bs + {1'b0, tbl_len[i]};
                        if (bs >= s && be <= e) begin
                            tbl_len[i] = 0;
                        end else if (s <= bs && e < be && e >= bs) begin
                            tbl_base[i] = e[51:0];
                            tbl_len[i] = 53'(be - e);
                        end else if (s > bs && s <= be && e >= be) begin
                            tbl_len[i] = 53'(s - bs);
                        end else if (s >= bs && e <= be) begin
                            tbl_len[i] = 0;
                            if (tbl_free(bs[52:0], 53'(s - bs)) != fra_pkg::ST_OK)
                                r.st = fra_pkg::ST_FULL;
                            if (tbl_free(e[52:0], 53'(be - e)) != fra_pkg::ST_OK)
                                r.st = fra_pkg::ST_FULL;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [52:0] rand_len();
        case ($urandom_range(0, 9))
            0: return 53'd0;
            1: return MAX53;
            2: return 53'({$urandom(), $urandom()});
            default: return 53'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [51:0] rand_frame();
        case ($urandom_range(0, 9))
            0: return 52'd0;
            1: return MAX52;
            2: return 52'({$urandom(), $urandom()});
            default: return 52'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic t_req rand_request();
        t_req rq;
        rq.op = ($urandom_range(0, 30) == 0) ? fra_pkg::OP_NOP : 2'($urandom_range(0, 2));
        rq.first = rand_frame();
        rq.count = rand_len();
        rq.fend = ($urandom_range(0, 3) == 0) ? 53'({$urandom(), $urandom()})
                                              : 53'(rq.first) + 53'($urandom_range(0, 60));
        if ($urandom_range(0, 12) == 0) rq.fend = 53'(rq.first) - 53'd1;
        return rq;
    endfunction

    function automatic t_row mk(logic [1:0] op, logic [51:0] f, logic [52:0] c,
                                logic [52:0] e, logic fx, logic [1:0] st, logic [51:0] fr);
        t_row r;
        r.rq = '{op: op, first: f, count: c, fend: e};
        r.fixed = fx;
        r.st = st;
        r.frame = fr;
        return r;
    endfunction

    task automatic send_request(t_req rq, logic fx, t_res fr);
        t_res p;
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        p = predict_request(rq);
        pending_results.push_back(p);
        fixed_results.push_back(fr);
        fixed_flags.push_back(fx);
        s_axis_tdata = {rq.fend, rq.count, rq.first, rq.op};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_res got, want;
        logic fx;
        t_res fr;
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("%0t timeout", $time);
            $display("** frame_range_allocator_core: FAILED **");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.st = m_axis_tdata[1:0];
            got.frame = m_axis_tdata[53:2];
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                fails++;
            end else begin
                want = pending_results.pop_front();
                fx = fixed_flags.pop_front();
                fr = fixed_results.pop_front();
                if (fx) want = fr;
                if (got.st !== want.st)
                    begin $display("%0t status exp %0d got %0d", $time, want.st, got.st);
                    fails++; end
                if (got.frame !== want.frame)
                    begin $display("%0t frame exp %h got %h", $time, want.frame, got.frame);
                    fails++; end
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) m_axis_tready <= 1'b0;
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int i, n;
        t_res fr;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        fails = 0;
        cycle = 0;
        quiet = 1'b0;
        hold_rx = 1'b0;
        for (i = 0; i < NREG; i++) begin tbl_base[i] = '0; tbl_len[i] = '0; end
        tbl_used = 0;

        rows[0]  = mk(fra_pkg::OP_ALLOC, 0, 5, 0, 1, fra_pkg::ST_NOFIT, 0);
        rows[1]  = mk(fra_pkg::OP_ALLOC, 0, 0, 0, 1, fra_pkg::ST_NOFIT, 0);
        rows[2]  = mk(fra_pkg::OP_FREE, 100, 0, 0, 1, fra_pkg::ST_OK, 0);
        rows[3]  = mk(fra_pkg::OP_RSV, 10, 0, 9, 1, fra_pkg::ST_ORDER, 0);
        rows[4]  = mk(fra_pkg::OP_NOP, MAX52, MAX53, MAX53, 1, fra_pkg::ST_OK, 0);
        rows[5]  = mk(fra_pkg::OP_FREE, 100, 50, 0, 1, fra_pkg::ST_OK, 0);
        rows[6]  = mk(fra_pkg::OP_ALLOC, 0, 10, 0, 1, fra_pkg::ST_OK, 100);
        rows[7]  = mk(fra_pkg::OP_FREE, 90, 20, 0, 0, fra_pkg::ST_OK, 0);
        rows[8]  = mk(fra_pkg::OP_FREE, 150, 5, 0, 0, fra_pkg::ST_OK, 0);
        rows[9]  = mk(fra_pkg::OP_ALLOC, 0, 0, 0, 0, fra_pkg::ST_OK, 0);
        rows[10] = mk(fra_pkg::OP_RSV, 120, 0, 130, 0, fra_pkg::ST_OK, 0);
        rows[11] = mk(fra_pkg::OP_RSV, 80, 0, 95, 0, fra_pkg::ST_OK, 0);
        rows[12] = mk(fra_pkg::OP_RSV, 150, 0, 200, 0, fra_pkg::ST_OK, 0);
        rows[13] = mk(fra_pkg::OP_FREE, MAX52 - 3, 4, 0, 0, fra_pkg::ST_OK, 0);
        rows[14] = mk(fra_pkg::OP_ALLOC, 0, 4, 0, 0, fra_pkg::ST_OK, 0);
        rows[15] = mk(fra_pkg::OP_FREE, 1000, MAX53, 0, 0, fra_pkg::ST_OK, 0);
        rows[16] = mk(fra_pkg::OP_FREE, 999, 1, 0, 0, fra_pkg::ST_OK, 0);
        rows[17] = mk(fra_pkg::OP_ALLOC, 0, MAX53, 0, 0, fra_pkg::ST_OK, 0);
        rows[18] = mk(fra_pkg::OP_RSV, 0, 0, MAX53, 0, fra_pkg::ST_OK, 0);
        rows[19] = mk(fra_pkg::OP_ALLOC, 0, 1, 0, 1, fra_pkg::ST_NOFIT, 0);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < NDIR; i++) begin
            fr = '{st: rows[i].st, frame: rows[i].frame};
            send_request(rows[i].rq, rows[i].fixed, fr);
        end

        // fill the table with disjoint ranges to reach the full cases
        for (i = 0; i < NREG + 2; i++)
            send_request('{op: fra_pkg::OP_FREE, first: 52'(5000 + i * 10), count: 3, fend: 0},
                         0, '0);
        send_request('{op: fra_pkg::OP_RSV, first: 5001, count: 0, fend: 5002}, 0, '0);

        hold_rx <= 1'b1;
        fork
            begin repeat (3000) @(negedge i_clk); hold_rx <= 1'b0; end
            for (n = 0; n < 5; n++) send_request(rand_request(), 0, '0);
        join

        for (n = 0; n < 1000; n++) begin
            if (n == 850) quiet = 1'b1;
            if (n % 200 == 199)
                send_request('{op: fra_pkg::OP_RSV, first: 0, count: 0, fend: MAX53}, 0, '0);
            else send_request(rand_request(), 0, '0);
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (fails == 0) $display("** frame_range_allocator_core: PASSED **");
        else $display("** frame_range_allocator_core: FAILED **");
        $finish;
    end
endmodule
